>>> hdl/qrm_pkg.sv
// shared constants and types for the quaternion to rotation matrix core
// no dependencies
package qrm_pkg;

  // fraction bits of the input and result fixed point format
  localparam int FRAC_BITS = 14;

  localparam int IN_W    = 16;             // input component width
  localparam int OUT_W   = 16;             // matrix entry width
  localparam int PROD_W  = 2 * IN_W;       // signed product width
  localparam int SQ_W    = PROD_W - 1;     // square magnitude width
  localparam int LEN_W   = SQ_W + 2;       // sum of four squares
  localparam int NUM_W   = LEN_W + 1;      // signed numerator
  localparam int TRIAL_W = LEN_W + 1;      // doubled remainder
  localparam int QUO_W   = FRAC_BITS + 2;  // quotient before final rounding
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int NUM_ENT = 9;
  localparam int NUM_SQ  = 4;
  localparam int NUM_CR  = 6;

  // value of one, clipped to the largest positive entry
  localparam int ONE_INT = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

  // square slots
  localparam int SQ_XX = 0;
  localparam int SQ_YY = 1;
  localparam int SQ_ZZ = 2;
  localparam int SQ_WW = 3;

  // cross product slots
  localparam int CR_XY = 0;
  localparam int CR_XZ = 1;
  localparam int CR_YZ = 2;
  localparam int CR_WX = 3;
  localparam int CR_WY = 4;
  localparam int CR_WZ = 5;

  typedef logic signed [OUT_W-1:0]  entry_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [TRIAL_W-1:0]       trial_t;
  typedef logic [QUO_W-1:0]         quo_t;
  typedef logic [NUM_ENT-1:0]       ent_mask_t;

endpackage

>>> hdl/quaternion_to_rotation_matrix_core.sv
// quaternion to 3x3 rotation matrix, pipelined, one quaternion per cycle
// depends on qrm_pkg
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  input     start_i / busy_o     quat_x_i, quat_y_i, quat_z_i, quat_w_i
//  result    done_o (strobe)      m_c<col>_r<row>_o (nine), degenerate_o
//
// a transfer may start in every cycle: busy_o stays low, the pipeline never
// blocks. each result passes stages 1 to 3, the restoring divider, one
// quotient bit per stage across nine lanes, and the output register. the
// receiver cannot stall, so done_o is a one-cycle strobe. reset clears only
// the valid bits.
module quaternion_to_rotation_matrix_core
  import qrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [IN_W-1:0]  quat_x_i,
  input  logic signed [IN_W-1:0]  quat_y_i,
  input  logic signed [IN_W-1:0]  quat_z_i,
  input  logic signed [IN_W-1:0]  quat_w_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] m_c0_r0_o,
  output logic signed [OUT_W-1:0] m_c1_r0_o,
  output logic signed [OUT_W-1:0] m_c2_r0_o,
  output logic signed [OUT_W-1:0] m_c0_r1_o,
  output logic signed [OUT_W-1:0] m_c1_r1_o,
  output logic signed [OUT_W-1:0] m_c2_r1_o,
  output logic signed [OUT_W-1:0] m_c0_r2_o,
  output logic signed [OUT_W-1:0] m_c1_r2_o,
  output logic signed [OUT_W-1:0] m_c2_r2_o,
  output logic                    degenerate_o
);

  localparam quo_t   LIM_Q   = QUO_W'(ONE_INT);
  localparam entry_t ONE_OUT = OUT_W'(ONE_INT);

  // stage 1: squares and cross products
  logic  p1_v_q;
  sq_t   sq_q [NUM_SQ];
  prod_t cr_q [NUM_CR];
  prod_t sq_full_c [NUM_SQ];
  prod_t cr_c [NUM_CR];

  // stage 2: squared length and numerators
  logic  p2_v_q;
  len_t  p2_len_q;
  num_t  num_q [NUM_ENT];
  len_t  len_d;
  num_t  num_d [NUM_ENT];
  num_t  sx_c [NUM_SQ];
  num_t  cx_c [NUM_CR];

  // stage 3: sign and magnitude, zero length detect
  logic      p3_v_q;
  len_t      p3_len_q;
  logic      p3_deg_q;
  ent_mask_t p3_neg_q;
  len_t      mag_q [NUM_ENT];

  // divider stages
  logic [DIV_STEPS-1:0] dv_q;
  len_t      dl_q   [DIV_STEPS];
  logic      dd_q   [DIV_STEPS];
  ent_mask_t dn_q   [DIV_STEPS];
  len_t      drem_q [DIV_STEPS][NUM_ENT];
  quo_t      dquo_q [DIV_STEPS][NUM_ENT];
  len_t      drem_d [DIV_STEPS][NUM_ENT];
  quo_t      dquo_d [DIV_STEPS][NUM_ENT];
  trial_t    trial_c [DIV_STEPS][NUM_ENT];

  // output register
  logic   done_q;
  logic   deg_q;
  entry_t res_q [NUM_ENT];
  entry_t res_d [NUM_ENT];
  logic [QUO_W:0] rnd_c [NUM_ENT];
  quo_t   sat_c [NUM_ENT];
  entry_t mag_out_c [NUM_ENT];

  // no backpressure anywhere in the pipe
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // stage 1: ten 16x16 multiplies
  always_comb begin
    sq_full_c[SQ_XX] = quat_x_i * quat_x_i;
    sq_full_c[SQ_YY] = quat_y_i * quat_y_i;
    sq_full_c[SQ_ZZ] = quat_z_i * quat_z_i;
    sq_full_c[SQ_WW] = quat_w_i * quat_w_i;
    cr_c[CR_XY] = quat_x_i * quat_y_i;
    cr_c[CR_XZ] = quat_x_i * quat_z_i;
    cr_c[CR_YZ] = quat_y_i * quat_z_i;
    cr_c[CR_WX] = quat_w_i * quat_x_i;
    cr_c[CR_WY] = quat_w_i * quat_y_i;
    cr_c[CR_WZ] = quat_w_i * quat_z_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SQ; i++) begin
      // squares are never negative and at most 2^30
      sq_q[i] <= sq_full_c[i][SQ_W-1:0];
    end
    for (int i = 0; i < NUM_CR; i++) begin
      cr_q[i] <= cr_c[i];
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: length and the nine numerators, all exact
  always_comb begin
    for (int i = 0; i < NUM_SQ; i++) begin
      sx_c[i] = $signed({3'b000, sq_q[i]});
    end
    for (int i = 0; i < NUM_CR; i++) begin
      cx_c[i] = NUM_W'(cr_q[i]);
    end
    len_d = LEN_W'(sq_q[SQ_XX]) + LEN_W'(sq_q[SQ_YY])
          + LEN_W'(sq_q[SQ_ZZ]) + LEN_W'(sq_q[SQ_WW]);
    // diagonal entries
    num_d[0] = sx_c[SQ_WW] + sx_c[SQ_XX] - sx_c[SQ_YY] - sx_c[SQ_ZZ];
    num_d[4] = sx_c[SQ_WW] - sx_c[SQ_XX] + sx_c[SQ_YY] - sx_c[SQ_ZZ];
    num_d[8] = sx_c[SQ_WW] - sx_c[SQ_XX] - sx_c[SQ_YY] + sx_c[SQ_ZZ];
    // off diagonal entries, doubled
    num_d[1] = (cx_c[CR_XY] - cx_c[CR_WZ]) <<< 1;
    num_d[2] = (cx_c[CR_XZ] + cx_c[CR_WY]) <<< 1;
    num_d[3] = (cx_c[CR_XY] + cx_c[CR_WZ]) <<< 1;
    num_d[5] = (cx_c[CR_YZ] - cx_c[CR_WX]) <<< 1;
    num_d[6] = (cx_c[CR_XZ] - cx_c[CR_WY]) <<< 1;
    num_d[7] = (cx_c[CR_YZ] + cx_c[CR_WX]) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    p2_len_q <= len_d;
    for (int e = 0; e < NUM_ENT; e++) begin
      num_q[e] <= num_d[e];
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: every numerator magnitude is bounded by the length
  always_ff @(posedge clk_i) begin
    p3_len_q <= p2_len_q;
    p3_deg_q <= (p2_len_q == '0);
    for (int e = 0; e < NUM_ENT; e++) begin
      p3_neg_q[e] <= num_q[e][NUM_W-1];
      mag_q[e]    <= num_q[e][NUM_W-1] ? LEN_W'(-num_q[e]) : LEN_W'(num_q[e]);
    end
  end

  // ---------------------------------------------------------------------
  // restoring divider: quotient floor(mag * 2^(FRAC_BITS+1) / len)
  // first stage yields the integer bit, each later one a fraction bit
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        if (k == 0) begin
          trial_c[k][e] = {1'b0, mag_q[e]};
          if (trial_c[k][e] >= {1'b0, p3_len_q}) begin
            drem_d[k][e] = LEN_W'(trial_c[k][e] - {1'b0, p3_len_q});
            dquo_d[k][e] = QUO_W'(1);
          end else begin
            drem_d[k][e] = LEN_W'(trial_c[k][e]);
            dquo_d[k][e] = '0;
          end
        end else begin
          trial_c[k][e] = {drem_q[k-1][e], 1'b0};
          if (trial_c[k][e] >= {1'b0, dl_q[k-1]}) begin
            drem_d[k][e] = LEN_W'(trial_c[k][e] - {1'b0, dl_q[k-1]});
            dquo_d[k][e] = {dquo_q[k-1][e][QUO_W-2:0], 1'b1};
          end else begin
            drem_d[k][e] = LEN_W'(trial_c[k][e]);
            dquo_d[k][e] = {dquo_q[k-1][e][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        dl_q[k] <= p3_len_q;
        dd_q[k] <= p3_deg_q;
        dn_q[k] <= p3_neg_q;
      end else begin
        dl_q[k] <= dl_q[k-1];
        dd_q[k] <= dd_q[k-1];
        dn_q[k] <= dn_q[k-1];
      end
      for (int e = 0; e < NUM_ENT; e++) begin
        drem_q[k][e] <= drem_d[k][e];
        dquo_q[k][e] <= dquo_d[k][e];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output stage: halve with rounding, clip to one, restore sign
  // zero length forces the identity matrix
  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      rnd_c[e]     = (QUO_W + 1)'(dquo_q[DIV_STEPS-1][e]) + 1'b1;
      sat_c[e]     = (rnd_c[e][QUO_W:1] > LIM_Q) ? LIM_Q : rnd_c[e][QUO_W:1];
      mag_out_c[e] = OUT_W'(sat_c[e]);
      if (dd_q[DIV_STEPS-1]) begin
        res_d[e] = (e == 0 || e == 4 || e == 8) ? ONE_OUT : '0;
      end else if (dn_q[DIV_STEPS-1][e]) begin
        res_d[e] = -mag_out_c[e];
      end else begin
        res_d[e] = mag_out_c[e];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= dd_q[DIV_STEPS-1];
    for (int e = 0; e < NUM_ENT; e++) begin
      res_q[e] <= res_d[e];
    end
  end

  // ---------------------------------------------------------------------
  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      dv_q   <= '0;
      done_q <= 1'b0;
    end else begin
      p1_v_q <= start_i && !busy_o;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      dv_q   <= {dv_q[DIV_STEPS-2:0], p3_v_q};
      done_q <= dv_q[DIV_STEPS-1];
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = deg_q;
  assign m_c0_r0_o    = res_q[0];
  assign m_c1_r0_o    = res_q[1];
  assign m_c2_r0_o    = res_q[2];
  assign m_c0_r1_o    = res_q[3];
  assign m_c1_r1_o    = res_q[4];
  assign m_c2_r1_o    = res_q[5];
  assign m_c0_r2_o    = res_q[6];
  assign m_c1_r2_o    = res_q[7];
  assign m_c2_r2_o    = res_q[8];

endmodule

>>> test/testbench.sv
// self-checking testbench for quaternion_to_rotation_matrix_core
// drives quaternions through the start/busy handshake, predicts each matrix and
// checks it against the done strobe; depends on qrm_pkg and the core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qrm_pkg::*;

  // pipeline depth plus margin, used for the quiet period at the end
  localparam int DRAIN_CYCLES = FRAC_BITS + 6 + 16;
  // generous bound on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int NUM_PHASES   = 4;
  localparam int MAX_REPORTS  = 10;

  // one quaternion waiting to be driven, with the idle pressure of its phase
  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] w;
    int                     idle_pct;
    bit                     wait_empty;
  } quat_item_t;

  // one rotation matrix as the core presents it
  typedef struct {
    entry_t m [NUM_ENT];
    logic   degenerate;
  } rot_matrix_t;

  logic                    clk_i    = 1'b0;
  logic                    rst_ni   = 1'b0;
  logic                    start_i  = 1'b0;
  logic signed [IN_W-1:0]  quat_x_i = '0;
  logic signed [IN_W-1:0]  quat_y_i = '0;
  logic signed [IN_W-1:0]  quat_z_i = '0;
  logic signed [IN_W-1:0]  quat_w_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic signed [OUT_W-1:0] m_c0_r0_o, m_c1_r0_o, m_c2_r0_o;
  logic signed [OUT_W-1:0] m_c0_r1_o, m_c1_r1_o, m_c2_r1_o;
  logic signed [OUT_W-1:0] m_c0_r2_o, m_c1_r2_o, m_c2_r2_o;
  logic                    degenerate_o;

  quat_item_t  pending_quats [$];
  rot_matrix_t expected_matrices [$];
  int          total_quats    = 0;
  int          accepted_quats = 0;
  int          cycle_count    = 0;
  int          error_count    = 0;
  int          mismatch_count = 0;
  bit          took_transfer  = 1'b0;

  quaternion_to_rotation_matrix_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .quat_w_i     (quat_w_i),
    .done_o       (done_o),
    .m_c0_r0_o    (m_c0_r0_o),
    .m_c1_r0_o    (m_c1_r0_o),
    .m_c2_r0_o    (m_c2_r0_o),
    .m_c0_r1_o    (m_c0_r1_o),
    .m_c1_r1_o    (m_c1_r1_o),
    .m_c2_r1_o    (m_c2_r1_o),
    .m_c0_r2_o    (m_c0_r2_o),
    .m_c1_r2_o    (m_c1_r2_o),
    .m_c2_r2_o    (m_c2_r2_o),
    .degenerate_o (degenerate_o)
  );

  always #5 clk_i = ~clk_i;

  // round(num * 2^FRAC_BITS / len2), half away from zero, clipped to one
  function automatic entry_t scaled_entry(longint num, longint len2);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< (FRAC_BITS + 1)) + len2) / (len2 <<< 1);
    if (q > ONE_INT) q = ONE_INT;
    return entry_t'((num < 0) ? -q : q);
  endfunction

  // full matrix for one quaternion, exact integer products, one rounding each
  function automatic rot_matrix_t rotation_of(logic signed [IN_W-1:0] qx,
                                              logic signed [IN_W-1:0] qy,
                                              logic signed [IN_W-1:0] qz,
                                              logic signed [IN_W-1:0] qw);
    longint x = qx;
    longint y = qy;
    longint z = qz;
    longint w = qw;
    longint len2;
    rot_matrix_t r;
    len2 = x * x + y * y + z * z + w * w;
    if (len2 == 0) begin
      // zero length gives the identity and flags it
      foreach (r.m[i]) r.m[i] = '0;
      r.m[0] = entry_t'(ONE_INT);
      r.m[4] = entry_t'(ONE_INT);
      r.m[8] = entry_t'(ONE_INT);
      r.degenerate = 1'b1;
    end else begin
      r.m[0] = scaled_entry(w * w + x * x - y * y - z * z, len2);
      r.m[1] = scaled_entry(2 * (x * y - w * z), len2);
      r.m[2] = scaled_entry(2 * (x * z + w * y), len2);
      r.m[3] = scaled_entry(2 * (x * y + w * z), len2);
      r.m[4] = scaled_entry(w * w - x * x + y * y - z * z, len2);
      r.m[5] = scaled_entry(2 * (y * z - w * x), len2);
      r.m[6] = scaled_entry(2 * (x * z - w * y), len2);
      r.m[7] = scaled_entry(2 * (y * z + w * x), len2);
      r.m[8] = scaled_entry(w * w - x * x - y * y + z * z, len2);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  task automatic add_quat(int x, int y, int z, int w, int idle_pct, bit wait_empty);
    quat_item_t item;
    item.x = IN_W'(x);
    item.y = IN_W'(y);
    item.z = IN_W'(z);
    item.w = IN_W'(w);
    item.idle_pct = idle_pct;
    item.wait_empty = wait_empty;
    pending_quats.push_back(item);
    total_quats++;
  endtask

  // random component, drawn from one of several shapes
  function automatic int random_component(int shape);
    int v;
    case (shape)
      0: v = int'($urandom_range(16)) - 8;                  // tiny magnitude
      1: v = ($urandom_range(1) == 0) ? 0 : int'($urandom()); // sparse
      2: v = int'($urandom_range(512)) - 256;               // near-unit noise
      default: v = int'($urandom());                        // full 16-bit range
    endcase
    return v;
  endfunction

  // driver: changes inputs on the falling edge, holds an item until taken
  always @(negedge clk_i) begin
    quat_item_t item;
    if (rst_ni && !(start_i && !took_transfer)) begin
      if (pending_quats.size() > 0 &&
          !(pending_quats[0].wait_empty && expected_matrices.size() > 0) &&
          int'($urandom_range(99)) >= pending_quats[0].idle_pct) begin
        item = pending_quats.pop_front();
        quat_x_i <= item.x;
        quat_y_i <= item.y;
        quat_z_i <= item.z;
        quat_w_i <= item.w;
        start_i  <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: samples on the rising edge, predicts on each input transfer
  // and checks each strobed result against the oldest prediction
  always @(posedge clk_i) begin
    rot_matrix_t got;
    rot_matrix_t want;
    bit bad;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_matrices.size());
      $display("testbench failed");
      $finish;
    end else begin
      took_transfer = rst_ni && start_i && !busy_o;
      if (took_transfer) begin
        expected_matrices.push_back(rotation_of(quat_x_i, quat_y_i, quat_z_i, quat_w_i));
        accepted_quats++;
      end
      if (rst_ni && done_o) begin
        got.m[0] = m_c0_r0_o;
        got.m[1] = m_c1_r0_o;
        got.m[2] = m_c2_r0_o;
        got.m[3] = m_c0_r1_o;
        got.m[4] = m_c1_r1_o;
        got.m[5] = m_c2_r1_o;
        got.m[6] = m_c0_r2_o;
        got.m[7] = m_c1_r2_o;
        got.m[8] = m_c2_r2_o;
        got.degenerate = degenerate_o;
        if (expected_matrices.size() == 0) begin
          // strobe with nothing in flight
          error_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d: result transfer with no quaternion in flight",
                     cycle_count);
        end else begin
          want = expected_matrices.pop_front();
          bad = 1'b0;
          foreach (want.m[i]) begin
            if (got.m[i] !== want.m[i]) begin
              bad = 1'b1;
              mismatch_count++;
              // entry index runs column first within a row
              if (mismatch_count <= MAX_REPORTS)
                $display("cycle %0d: m_c%0d_r%0d expected %0d got %0d",
                         cycle_count, i % 3, i / 3, want.m[i], got.m[i]);
            end
          end
          if (got.degenerate !== want.degenerate) begin
            bad = 1'b1;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("cycle %0d: degenerate expected %0b got %0b",
                       cycle_count, want.degenerate, got.degenerate);
          end
          if (bad) error_count++;
        end
      end
    end
  end

  initial begin
    int idle_pct;
    int shape;
    // idle percentage of the sender per phase; the receiver cannot stall,
    // so the phases that would stall it run without idling
    int phase_idle [NUM_PHASES];
    phase_idle = '{0, 79, 0, 38};

    // directed part: zero length, unit axes, sign and magnitude extremes
    add_quat(0, 0, 0, 0, 0, 1'b0);
    add_quat(0, 0, 0, 16384, 0, 1'b0);
    add_quat(0, 0, 0, -16384, 0, 1'b0);
    add_quat(16384, 0, 0, 0, 0, 1'b0);
    add_quat(0, 16384, 0, 0, 0, 1'b0);
    add_quat(0, 0, 16384, 0, 0, 1'b0);
    add_quat(-16384, 0, 0, 0, 0, 1'b0);
    add_quat(-32768, -32768, -32768, -32768, 0, 1'b0);
    add_quat(32767, 32767, 32767, 32767, 0, 1'b0);
    add_quat(32767, -32768, 32767, -32768, 0, 1'b0);
    add_quat(-32768, 0, 0, 0, 0, 1'b0);
    add_quat(0, 0, 0, 32767, 0, 1'b0);
    add_quat(1, 0, 0, 0, 0, 1'b0);
    add_quat(0, 0, 0, -1, 0, 1'b0);
    add_quat(-1, -1, -1, -1, 0, 1'b0);
    add_quat(1, 1, 1, 1, 0, 1'b0);
    add_quat(3, 1, 1, 1, 0, 1'b0);
    add_quat(32767, 32767, 0, 0, 0, 1'b0);
    add_quat(-32768, 0, 0, 1, 0, 1'b0);
    add_quat(0, -32768, 32767, 0, 0, 1'b0);
    add_quat(11585, 11585, 0, 0, 0, 1'b0);
    add_quat(8192, -8192, 8192, -8192, 0, 1'b0);
    add_quat(0, 0, 0, 0, 0, 1'b0);

    // random part in phases; the first item of each later phase waits
    // until every result of the previous phase has come out
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        shape = int'($urandom_range(9));
        if (shape < 5) shape = 3;
        else if (shape < 7) shape = 0;
        else if (shape < 9) shape = 1;
        else shape = 2;
        if (shape == 2)
          // near-unit quaternion: a dominant axis plus small noise
          add_quat(random_component(2), random_component(2), random_component(2),
                   ($urandom_range(1) == 0) ? 16384 : -16384, idle_pct,
                   (p > 0 && n == 0));
        else
          add_quat(random_component(shape), random_component(shape),
                   random_component(shape), random_component(shape), idle_pct,
                   (p > 0 && n == 0));
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // all items in, all results out, then a quiet stretch for stray strobes
    while (accepted_quats != total_quats || expected_matrices.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && expected_matrices.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/qrm_pkg.sv
hdl/quaternion_to_rotation_matrix_core.sv
test/testbench.sv
